// ===== rtl/rbs_pkg.sv =====
// Shared constants and types for the RGBA bilinear scaler.
package rbs_pkg;

    // Source store and fraction sizes
    localparam int MAX_SRC_WIDTH  = 128;
    localparam int MAX_SRC_HEIGHT = 128;
    localparam int FRAC_BITS      = 8;

    // Field widths
    localparam int POS_W        = 12;
    localparam int SRC_SIZE_W   = 8;
    localparam int DST_SIZE_W   = 13;
    localparam int TARGET_LIMIT = 4096;
    localparam int CH_W         = 8;
    localparam int PIX_W        = 4 * CH_W;

    // Source index width covers both axes
    localparam int MAX_SRC_DIM = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH
                                                                  : MAX_SRC_HEIGHT;
    localparam int IDX_W = $clog2(MAX_SRC_DIM);

    // Divider geometry: quotient holds index and fraction together
    localparam int QW      = IDX_W + FRAC_BITS;
    localparam int NUM_W   = POS_W + IDX_W;
    localparam int DVD_W   = NUM_W + FRAC_BITS;
    localparam int REM_W   = DVD_W - QW;
    localparam int DIV_PER = 3;
    localparam int DIV_ST  = (QW + DIV_PER - 1) / DIV_PER;

    // Pipeline depth: axis stages, then read, weight, sum and output
    localparam int AX_ST = DIV_ST + 3;
    localparam int NST   = AX_ST + 4;

    // Parity banks: four banks addressed by half row and half column
    localparam int BANK_AW    = 2 * (IDX_W - 1);
    localparam int BANK_DEPTH = 1 << BANK_AW;

    // Weight and sum widths
    localparam int W_W   = 2 * (FRAC_BITS + 1);
    localparam int SUM_W = W_W + CH_W + 2;

    // Commands
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_COMPUTE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;

    // Item traveling down the pipeline
    typedef struct packed {
        logic             cmd;
        logic             wr;
        logic [POS_W-1:0] px;
        logic [POS_W-1:0] py;
        logic [PIX_W-1:0] rgba;
    } item_t;

    // Result of one axis mapping
    typedef struct packed {
        logic [IDX_W-1:0]     i0;
        logic [IDX_W-1:0]     i1;
        logic [FRAC_BITS-1:0] frac;
    } axis_t;

endpackage

// ===== rtl/rbs_axis.sv =====
// Axis mapper: destination coordinate to source index pair and fraction.
module rbs_axis (
    input  logic                          clk,
    input  logic [rbs_pkg::AX_ST-1:0]     en,
    input  logic [rbs_pkg::POS_W-1:0]     d,
    input  logic [rbs_pkg::IDX_W-1:0]     sm1,
    input  logic [rbs_pkg::DST_SIZE_W-1:0] dst,
    output rbs_pkg::axis_t                res
);

    localparam int DS = rbs_pkg::DIV_ST;

    // Stage A: saturate coordinate, form divisor
    logic [rbs_pkg::POS_W-1:0]      d_a_reg;
    logic [rbs_pkg::IDX_W-1:0]      sm1_a_reg;
    logic [rbs_pkg::POS_W-1:0]      den_a_reg;
    logic                           one_a_reg;
    logic [rbs_pkg::DST_SIZE_W-1:0] dm1;

    assign dm1 = dst - rbs_pkg::DST_SIZE_W'(1);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d_a_reg   <= ({1'b0, d} >= dst) ? dm1[rbs_pkg::POS_W-1:0] : d;
            sm1_a_reg <= sm1;
            den_a_reg <= dm1[rbs_pkg::POS_W-1:0];
            one_a_reg <= (dst <= rbs_pkg::DST_SIZE_W'(1));
        end
    end

    // Stage B: numerator product
    logic [rbs_pkg::NUM_W-1:0] num_b_reg;
    logic [rbs_pkg::IDX_W-1:0] sm1_b_reg;
    logic [rbs_pkg::POS_W-1:0] den_b_reg;
    logic                      one_b_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            num_b_reg <= rbs_pkg::NUM_W'(d_a_reg) * rbs_pkg::NUM_W'(sm1_a_reg);
            sm1_b_reg <= sm1_a_reg;
            den_b_reg <= den_a_reg;
            one_b_reg <= one_a_reg;
        end
    end

    // Restoring divider, DIV_PER quotient bits per stage
    logic [rbs_pkg::REM_W-1:0] rem_reg [DS];
    logic [rbs_pkg::QW-1:0]    q_reg   [DS];
    logic [rbs_pkg::DVD_W-1:0] dvd_reg [DS];
    logic [rbs_pkg::POS_W-1:0] den_reg [DS];
    logic [rbs_pkg::IDX_W-1:0] sm1_reg [DS];
    logic                      one_reg [DS];

    genvar s;
    generate
        for (s = 0; s < DS; s++)
        begin : g_div
            logic [rbs_pkg::REM_W-1:0] rem_in;
            logic [rbs_pkg::QW-1:0]    q_in;
            logic [rbs_pkg::DVD_W-1:0] dvd_in;
            logic [rbs_pkg::POS_W-1:0] den_in;
            logic [rbs_pkg::IDX_W-1:0] sm1_in;
            logic                      one_in;
            logic [rbs_pkg::REM_W-1:0] rem_next;
            logic [rbs_pkg::QW-1:0]    q_next;

            if (s == 0)
            begin : g_first
                assign dvd_in = {num_b_reg, {rbs_pkg::FRAC_BITS{1'b0}}};
                assign rem_in = dvd_in[rbs_pkg::DVD_W-1:rbs_pkg::QW];
                assign q_in   = '0;
                assign den_in = den_b_reg;
                assign sm1_in = sm1_b_reg;
                assign one_in = one_b_reg;
            end
            else
            begin : g_rest
                assign dvd_in = dvd_reg[s-1];
                assign rem_in = rem_reg[s-1];
                assign q_in   = q_reg[s-1];
                assign den_in = den_reg[s-1];
                assign sm1_in = sm1_reg[s-1];
                assign one_in = one_reg[s-1];
            end

            // Shift in one dividend bit, subtract when it fits
            always_comb
            begin
                int k;
                logic [rbs_pkg::REM_W:0] trial;
                rem_next = rem_in;
                q_next   = q_in;
                for (int j = 0; j < rbs_pkg::DIV_PER; j++)
                begin
                    k = rbs_pkg::QW - 1 - (s * rbs_pkg::DIV_PER + j);
                    if (k >= 0)
                    begin
                        trial = {rem_next, dvd_in[k]};
                        if (trial >= {1'b0, den_in})
                        begin
                            trial     = trial - {1'b0, den_in};
                            q_next[k] = 1'b1;
                        end
                        rem_next = trial[rbs_pkg::REM_W-1:0];
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[2+s])
                begin
                    rem_reg[s] <= rem_next;
                    q_reg[s]   <= q_next;
                    dvd_reg[s] <= dvd_in;
                    den_reg[s] <= den_in;
                    sm1_reg[s] <= sm1_in;
                    one_reg[s] <= one_in;
                end
            end
        end
    endgenerate

    // Final stage: split quotient, clamp the upper neighbor
    logic [rbs_pkg::IDX_W-1:0]     i0;
    logic [rbs_pkg::FRAC_BITS-1:0] fr;

    assign i0 = one_reg[DS-1] ? '0 : q_reg[DS-1][rbs_pkg::QW-1:rbs_pkg::FRAC_BITS];
    assign fr = one_reg[DS-1] ? '0 : q_reg[DS-1][rbs_pkg::FRAC_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (en[rbs_pkg::AX_ST-1])
        begin
            res.i0   <= i0;
            res.i1   <= (i0 == sm1_reg[DS-1]) ? i0 : i0 + rbs_pkg::IDX_W'(1);
            res.frac <= fr;
        end
    end

endmodule

// ===== rtl/rgba_bilinear_scaler.sv =====
// Top level of the corner-aligned RGBA bilinear scaler.
//
// Load items write one source pixel; compute items return one interpolated
// pixel. The pipeline is NST (12) stages deep and takes one item every clock
// while out_stall does not hold it back.
// Both axis mappings run through a restoring divider that retires three
// quotient bits per stage. The source store is split into four parity banks
// (row and column parity) so that the four neighbors are read in the same cycle;
// loads write the banks at the same stage that computes read them, so store
// order follows item order. Store entries have no reset value.
module rgba_bilinear_scaler (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration port
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [rbs_pkg::DST_SIZE_W-1:0] cfg_data,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [rbs_pkg::POS_W-1:0]     pos_x,
    input  logic [rbs_pkg::POS_W-1:0]     pos_y,
    input  logic [rbs_pkg::CH_W-1:0]      in_red,
    input  logic [rbs_pkg::CH_W-1:0]      in_green,
    input  logic [rbs_pkg::CH_W-1:0]      in_blue,
    input  logic [rbs_pkg::CH_W-1:0]      in_alpha,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rbs_pkg::CH_W-1:0]      out_red,
    output logic [rbs_pkg::CH_W-1:0]      out_green,
    output logic [rbs_pkg::CH_W-1:0]      out_blue,
    output logic [rbs_pkg::CH_W-1:0]      out_alpha
);

    localparam int NST   = rbs_pkg::NST;
    localparam int AX    = rbs_pkg::AX_ST;
    localparam int RD    = AX;
    localparam int WT    = AX + 1;
    localparam int SM    = AX + 2;
    localparam int OT    = AX + 3;
    localparam int FB    = rbs_pkg::FRAC_BITS;
    localparam int IW    = rbs_pkg::IDX_W;
    localparam int CW    = rbs_pkg::CH_W;

    // Configuration registers
    logic [rbs_pkg::SRC_SIZE_W-1:0] src_w_reg, src_h_reg;
    logic [rbs_pkg::DST_SIZE_W-1:0] dst_w_reg, dst_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= rbs_pkg::SRC_SIZE_W'(128);
            src_h_reg <= rbs_pkg::SRC_SIZE_W'(128);
            dst_w_reg <= rbs_pkg::DST_SIZE_W'(128);
            dst_h_reg <= rbs_pkg::DST_SIZE_W'(128);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                rbs_pkg::REG_SRC_W: src_w_reg <= cfg_data[rbs_pkg::SRC_SIZE_W-1:0];
                rbs_pkg::REG_SRC_H: src_h_reg <= cfg_data[rbs_pkg::SRC_SIZE_W-1:0];
                rbs_pkg::REG_DST_W: dst_w_reg <= cfg_data;
                rbs_pkg::REG_DST_H: dst_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, oversize saturates
    logic [rbs_pkg::SRC_SIZE_W-1:0] sw_c, sh_c;
    logic [rbs_pkg::DST_SIZE_W-1:0] dw_c, dh_c;
    logic [rbs_pkg::SRC_SIZE_W-1:0] swm1, shm1;

    always_comb
    begin
        sw_c = (src_w_reg == '0) ? rbs_pkg::SRC_SIZE_W'(1) :
               (32'(src_w_reg) > rbs_pkg::MAX_SRC_WIDTH) ?
               rbs_pkg::SRC_SIZE_W'(rbs_pkg::MAX_SRC_WIDTH) : src_w_reg;
        sh_c = (src_h_reg == '0) ? rbs_pkg::SRC_SIZE_W'(1) :
               (32'(src_h_reg) > rbs_pkg::MAX_SRC_HEIGHT) ?
               rbs_pkg::SRC_SIZE_W'(rbs_pkg::MAX_SRC_HEIGHT) : src_h_reg;
        dw_c = (dst_w_reg == '0) ? rbs_pkg::DST_SIZE_W'(1) :
               (32'(dst_w_reg) > rbs_pkg::TARGET_LIMIT) ?
               rbs_pkg::DST_SIZE_W'(rbs_pkg::TARGET_LIMIT) : dst_w_reg;
        dh_c = (dst_h_reg == '0) ? rbs_pkg::DST_SIZE_W'(1) :
               (32'(dst_h_reg) > rbs_pkg::TARGET_LIMIT) ?
               rbs_pkg::DST_SIZE_W'(rbs_pkg::TARGET_LIMIT) : dst_h_reg;
        swm1 = sw_c - rbs_pkg::SRC_SIZE_W'(1);
        shm1 = sh_c - rbs_pkg::SRC_SIZE_W'(1);
    end

    // Stage valids and per-stage advance enables
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_stall  = !en[0];
    assign out_valid = vld_reg[NST-1];

    // Item payload through the axis stages
    rbs_pkg::item_t item_reg [AX];
    rbs_pkg::item_t item_in;

    always_comb
    begin
        item_in.cmd  = command;
        item_in.wr   = ({4'd0, pos_x} < 16'(sw_c)) && ({4'd0, pos_y} < 16'(sh_c));
        item_in.px   = pos_x;
        item_in.py   = pos_y;
        item_in.rgba = {in_alpha, in_blue, in_green, in_red};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            item_reg[0] <= item_in;
        end
        for (int k = 1; k < AX; k++)
        begin
            if (en[k])
            begin
                item_reg[k] <= item_reg[k-1];
            end
        end
    end

    // Valid bits; loads drop out at the store access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    if (k == RD)
                    begin
                        vld_reg[k] <= vld_reg[k-1] &&
                                      (item_reg[AX-1].cmd == rbs_pkg::CMD_COMPUTE);
                    end
                    else
                    begin
                        vld_reg[k] <= vld_reg[k-1];
                    end
                end
            end
        end
    end

    // Axis mappers
    rbs_pkg::axis_t ax_x, ax_y;

    rbs_axis u_axis_x (
        .clk (clk),
        .en  (en[AX-1:0]),
        .d   (pos_x),
        .sm1 (swm1[IW-1:0]),
        .dst (dw_c),
        .res (ax_x)
    );

    rbs_axis u_axis_y (
        .clk (clk),
        .en  (en[AX-1:0]),
        .d   (pos_y),
        .sm1 (shm1[IW-1:0]),
        .dst (dh_c),
        .res (ax_y)
    );

    // Bank addresses: even/odd half index for each axis
    logic [IW-2:0] col_e, col_o, row_e, row_o;
    logic [IW-2:0] ld_col, ld_row;
    logic [rbs_pkg::BANK_AW-1:0] rd_addr [4];
    logic [rbs_pkg::BANK_AW-1:0] wr_addr;
    logic [3:0] bank_we;
    logic       rd_en;

    always_comb
    begin
        col_e  = ax_x.i0[0] ? ax_x.i1[IW-1:1] : ax_x.i0[IW-1:1];
        col_o  = ax_x.i0[0] ? ax_x.i0[IW-1:1] : ax_x.i1[IW-1:1];
        row_e  = ax_y.i0[0] ? ax_y.i1[IW-1:1] : ax_y.i0[IW-1:1];
        row_o  = ax_y.i0[0] ? ax_y.i0[IW-1:1] : ax_y.i1[IW-1:1];
        // bank index is {row parity, column parity}
        rd_addr[0] = {row_e, col_e};
        rd_addr[1] = {row_e, col_o};
        rd_addr[2] = {row_o, col_e};
        rd_addr[3] = {row_o, col_o};
        ld_col  = item_reg[AX-1].px[IW-1:1];
        ld_row  = item_reg[AX-1].py[IW-1:1];
        wr_addr = {ld_row, ld_col};
        rd_en   = en[RD];
        bank_we = '0;
        if (en[RD] && vld_reg[AX-1] && (item_reg[AX-1].cmd == rbs_pkg::CMD_LOAD) &&
            item_reg[AX-1].wr)
        begin
            bank_we[{item_reg[AX-1].py[0], item_reg[AX-1].px[0]}] = 1'b1;
        end
    end

    // Parity-banked source store
    logic [rbs_pkg::PIX_W-1:0] bank_q_reg [4];

    genvar b;
    generate
        for (b = 0; b < 4; b++)
        begin : g_bank
            logic [rbs_pkg::PIX_W-1:0] mem [rbs_pkg::BANK_DEPTH];

            always_ff @(posedge clk)
            begin
                if (bank_we[b])
                begin
                    mem[wr_addr] <= item_reg[AX-1].rgba;
                end
                if (rd_en)
                begin
                    bank_q_reg[b] <= mem[rd_addr[b]];
                end
            end
        end
    endgenerate

    // Read stage side data
    logic          x0p_reg, x1p_reg, y0p_reg, y1p_reg;
    logic [FB-1:0] fx_reg, fy_reg;

    always_ff @(posedge clk)
    begin
        if (en[RD])
        begin
            x0p_reg <= ax_x.i0[0];
            x1p_reg <= ax_x.i1[0];
            y0p_reg <= ax_y.i0[0];
            y1p_reg <= ax_y.i1[0];
            fx_reg  <= ax_x.frac;
            fy_reg  <= ax_y.frac;
        end
    end

    // Weight stage: pick neighbors, form weights
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;
    logic [FB:0] ofx, ofy;
    logic [rbs_pkg::PIX_W-1:0] p00_reg, p10_reg, p01_reg, p11_reg;
    logic [rbs_pkg::W_W-1:0]   w00_reg, w10_reg, w01_reg, w11_reg;

    assign ofx = ONE - {1'b0, fx_reg};
    assign ofy = ONE - {1'b0, fy_reg};

    always_ff @(posedge clk)
    begin
        if (en[WT])
        begin
            p00_reg <= bank_q_reg[{y0p_reg, x0p_reg}];
            p10_reg <= bank_q_reg[{y0p_reg, x1p_reg}];
            p01_reg <= bank_q_reg[{y1p_reg, x0p_reg}];
            p11_reg <= bank_q_reg[{y1p_reg, x1p_reg}];
            w00_reg <= rbs_pkg::W_W'(ofx) * rbs_pkg::W_W'(ofy);
            w10_reg <= rbs_pkg::W_W'(fx_reg) * rbs_pkg::W_W'(ofy);
            w01_reg <= rbs_pkg::W_W'(ofx) * rbs_pkg::W_W'(fy_reg);
            w11_reg <= rbs_pkg::W_W'(fx_reg) * rbs_pkg::W_W'(fy_reg);
        end
    end

    // Sum stage: weighted sum per channel
    logic [rbs_pkg::SUM_W-1:0] sum_reg [4];

    always_ff @(posedge clk)
    begin
        if (en[SM])
        begin
            for (int c = 0; c < 4; c++)
            begin
                sum_reg[c] <=
                    rbs_pkg::SUM_W'(w00_reg) * rbs_pkg::SUM_W'(p00_reg[c*CW +: CW]) +
                    rbs_pkg::SUM_W'(w10_reg) * rbs_pkg::SUM_W'(p10_reg[c*CW +: CW]) +
                    rbs_pkg::SUM_W'(w01_reg) * rbs_pkg::SUM_W'(p01_reg[c*CW +: CW]) +
                    rbs_pkg::SUM_W'(w11_reg) * rbs_pkg::SUM_W'(p11_reg[c*CW +: CW]);
            end
        end
    end

    // Output stage: round, shift, clamp
    localparam logic [rbs_pkg::SUM_W-1:0] HALF = rbs_pkg::SUM_W'(1) << (2*FB - 1);
    logic [CW-1:0] chan_reg [4];

    always_ff @(posedge clk)
    begin
        logic [rbs_pkg::SUM_W-1:0] t;
        if (en[OT])
        begin
            for (int c = 0; c < 4; c++)
            begin
                t = (sum_reg[c] + HALF) >> (2*FB);
                chan_reg[c] <= (t > rbs_pkg::SUM_W'(255)) ? CW'(255) : t[CW-1:0];
            end
        end
    end

    assign out_red   = chan_reg[0];
    assign out_green = chan_reg[1];
    assign out_blue  = chan_reg[2];
    assign out_alpha = chan_reg[3];

    // Checks
    a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[RD] && !en[WT] |=> $stable(bank_q_reg[0]) && $stable(bank_q_reg[3]))
        else $error("store read data changed under stall");

    a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(bank_we))
        else $error("more than one bank written");

    a_x_pair: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[AX-1] && (item_reg[AX-1].cmd == rbs_pkg::CMD_COMPUTE) |->
        (ax_x.i1 == ax_x.i0) || (ax_x.i1 == ax_x.i0 + IW'(1)))
        else $error("x neighbor pair malformed");

    a_single_col: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[AX-1] && (item_reg[AX-1].cmd == rbs_pkg::CMD_COMPUTE) &&
        (dw_c == rbs_pkg::DST_SIZE_W'(1)) |-> (ax_x.frac == '0) && (ax_x.i0 == '0))
        else $error("single-column target gave nonzero position");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the RGBA bilinear scaler.

// Tracks store contents and settings, predicts each pixel, checks results
class pixel_scoreboard;
    bit [rbs_pkg::PIX_W-1:0] store [rbs_pkg::MAX_SRC_WIDTH*rbs_pkg::MAX_SRC_HEIGHT];
    bit [rbs_pkg::SRC_SIZE_W-1:0] src_w_reg;
    bit [rbs_pkg::SRC_SIZE_W-1:0] src_h_reg;
    bit [rbs_pkg::DST_SIZE_W-1:0] dst_w_reg;
    bit [rbs_pkg::DST_SIZE_W-1:0] dst_h_reg;
    bit [rbs_pkg::PIX_W-1:0] pending_pixels [$];
    int errors;

    function new();
        src_w_reg = 128;
        src_h_reg = 128;
        dst_w_reg = 128;
        dst_h_reg = 128;
        errors = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [rbs_pkg::DST_SIZE_W-1:0] v);
        case (idx)
            rbs_pkg::REG_SRC_W: src_w_reg = v[rbs_pkg::SRC_SIZE_W-1:0];
            rbs_pkg::REG_SRC_H: src_h_reg = v[rbs_pkg::SRC_SIZE_W-1:0];
            rbs_pkg::REG_DST_W: dst_w_reg = v;
            rbs_pkg::REG_DST_H: dst_h_reg = v;
            default: ;
        endcase
    endfunction

    // Zero acts as one, oversize saturates
    function int eff_size(int v, int lim);
        if (v == 0)
            return 1;
        return (v > lim) ? lim : v;
    endfunction

    function int src_w();
        return eff_size(src_w_reg, rbs_pkg::MAX_SRC_WIDTH);
    endfunction
    function int src_h();
        return eff_size(src_h_reg, rbs_pkg::MAX_SRC_HEIGHT);
    endfunction
    function int dst_w();
        return eff_size(dst_w_reg, rbs_pkg::TARGET_LIMIT);
    endfunction
    function int dst_h();
        return eff_size(dst_h_reg, rbs_pkg::TARGET_LIMIT);
    endfunction

    // Corner-aligned mapping of one destination coordinate
    function void map_axis(int d, int src, int dst, output int i0, output int i1,
                           output int frac);
        int num;
        int den;
        if (d >= dst)
            d = dst - 1;
        if (dst <= 1)
        begin
            i0 = 0;
            frac = 0;
        end
        else
        begin
            den = dst - 1;
            num = d * (src - 1);
            i0 = num / den;
            frac = ((num % den) << rbs_pkg::FRAC_BITS) / den;
        end
        i1 = (i0 + 1 < src) ? i0 + 1 : src - 1;
    endfunction

    function void note_input(bit cmd, bit [rbs_pkg::POS_W-1:0] x,
                             bit [rbs_pkg::POS_W-1:0] y, bit [rbs_pkg::PIX_W-1:0] rgba);
        int x0, x1, fx, y0, y1, fy;
        longint w00, w10, w01, w11, s;
        bit [rbs_pkg::PIX_W-1:0] p00, p10, p01, p11, pix;
        int one;
        int cw;
        cw = rbs_pkg::CH_W;
        if (cmd == rbs_pkg::CMD_LOAD)
        begin
            if (x < src_w() && y < src_h())
                store[y*rbs_pkg::MAX_SRC_WIDTH + x] = rgba;
            return;
        end
        one = 1 << rbs_pkg::FRAC_BITS;
        map_axis(x, src_w(), dst_w(), x0, x1, fx);
        map_axis(y, src_h(), dst_h(), y0, y1, fy);
        p00 = store[y0*rbs_pkg::MAX_SRC_WIDTH + x0];
        p10 = store[y0*rbs_pkg::MAX_SRC_WIDTH + x1];
        p01 = store[y1*rbs_pkg::MAX_SRC_WIDTH + x0];
        p11 = store[y1*rbs_pkg::MAX_SRC_WIDTH + x1];
        w00 = (one - fx) * (one - fy);
        w10 = fx * (one - fy);
        w01 = (one - fx) * fy;
        w11 = fx * fy;
        for (int ch = 0; ch < 4; ch++)
        begin
            s = w00 * p00[ch*cw +: 8] + w10 * p10[ch*cw +: 8]
              + w01 * p01[ch*cw +: 8] + w11 * p11[ch*cw +: 8];
            s = (s + (64'd1 << (2*rbs_pkg::FRAC_BITS-1))) >> (2*rbs_pkg::FRAC_BITS);
            pix[ch*cw +: 8] = (s > 255) ? 8'd255 : s[7:0];
        end
        pending_pixels.push_back(pix);
    endfunction

    function void check_result(bit [rbs_pkg::PIX_W-1:0] got);
        bit [rbs_pkg::PIX_W-1:0] exp_pix;
        string names [4];
        int cw;
        cw = rbs_pkg::CH_W;
        names = '{"out_red", "out_green", "out_blue", "out_alpha"};
        if (pending_pixels.size() == 0)
        begin
            $error("unexpected output pixel %h", got);
            errors++;
            return;
        end
        exp_pix = pending_pixels.pop_front();
        for (int ch = 0; ch < 4; ch++)
        begin
            if (got[ch*cw +: 8] !== exp_pix[ch*cw +: 8])
            begin
                $error("%s expected %0d actual %0d", names[ch],
                       exp_pix[ch*cw +: 8], got[ch*cw +: 8]);
                errors++;
            end
        end
    endfunction
endclass

module tb;
    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_write = 1'b0;
    logic [1:0]                     cfg_index = '0;
    logic [rbs_pkg::DST_SIZE_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic                           command = rbs_pkg::CMD_LOAD;
    logic [rbs_pkg::POS_W-1:0]      pos_x = '0;
    logic [rbs_pkg::POS_W-1:0]      pos_y = '0;
    logic [rbs_pkg::CH_W-1:0]       in_red = '0;
    logic [rbs_pkg::CH_W-1:0]       in_green = '0;
    logic [rbs_pkg::CH_W-1:0]       in_blue = '0;
    logic [rbs_pkg::CH_W-1:0]       in_alpha = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [rbs_pkg::CH_W-1:0]       out_red;
    logic [rbs_pkg::CH_W-1:0]       out_green;
    logic [rbs_pkg::CH_W-1:0]       out_blue;
    logic [rbs_pkg::CH_W-1:0]       out_alpha;

    pixel_scoreboard sb = new();
    bit hold_req = 0;
    bit no_idle = 0;
    int idle_cycles = 0;

    localparam int WATCHDOG_LIMIT = 5000;

    rgba_bilinear_scaler dut (.*);

    always #6 clk = ~clk;

    // Check results first, then record accepted items
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result({out_alpha, out_blue, out_green, out_red});
        if (rst_n && in_valid && !in_stall)
            sb.note_input(command, pos_x, pos_y, {in_alpha, in_blue, in_green, in_red});
    end

    // Watchdog on cycles without any accepted item or taken result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[rgba_bilinear_scaler] ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold on request
    initial
    begin
        int r;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 0;
            end
            else if (no_idle || r < 65)
                out_stall <= 1'b0;
            else if (r < 95)
                out_stall <= 1'b1;
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    task automatic send_item(bit cmd, int x, int y, bit [rbs_pkg::PIX_W-1:0] rgba);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (no_idle || r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3)
                                                 : $urandom_range(5, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        pos_x    <= rbs_pkg::POS_W'(x);
        pos_y    <= rbs_pkg::POS_W'(y);
        {in_alpha, in_blue, in_green, in_red} <= rgba;
        do @(posedge clk); while (in_stall);
    endtask

    // Pause until every expected pixel is out, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge clk);
        repeat (rbs_pkg::NST + 8) @(posedge clk);
    endtask

    task automatic write_cfg(bit [1:0] idx, int v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= rbs_pkg::DST_SIZE_W'(v);
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.write_reg(idx, rbs_pkg::DST_SIZE_W'(v));
    endtask

    // New settings, then fill the whole source region so no unwritten read occurs
    task automatic start_phase(int sw, int sh, int dw, int dh);
        drain();
        write_cfg(rbs_pkg::REG_SRC_W, sw);
        write_cfg(rbs_pkg::REG_SRC_H, sh);
        write_cfg(rbs_pkg::REG_DST_W, dw);
        write_cfg(rbs_pkg::REG_DST_H, dh);
        for (int y = 0; y < sb.src_h(); y++)
        begin
            for (int x = 0; x < sb.src_w(); x++)
            begin
                send_item(rbs_pkg::CMD_LOAD, x, y, $urandom);
            end
        end
    endtask

    // Random mix of computes, in-range loads and ignored loads
    task automatic random_items(int n, bit pressure);
        int r;
        int x;
        int y;
        for (int i = 0; i < n; i++)
        begin
            if (pressure && i == n / 3)
                hold_req = 1;
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    x = $urandom_range(0, sb.dst_w() - 1);
                    y = $urandom_range(0, sb.dst_h() - 1);
                end
                else if (r < 80)
                begin
                    x = $urandom_range(0, 1) ? 0 : sb.dst_w() - 1;
                    y = $urandom_range(0, 1) ? 0 : sb.dst_h() - 1;
                end
                else
                begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end
                send_item(rbs_pkg::CMD_COMPUTE, x, y, $urandom);
            end
            else if (r < 80)
                send_item(rbs_pkg::CMD_LOAD, $urandom_range(0, sb.src_w() - 1),
                          $urandom_range(0, sb.src_h() - 1), $urandom);
            else
                send_item(rbs_pkg::CMD_LOAD, $urandom_range(0, 4095),
                          $urandom_range(0, 4095), $urandom);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small image, corners, mid points, beyond-target and ignored loads
        start_phase(4, 3, 7, 5);
        send_item(rbs_pkg::CMD_LOAD, 0, 0, 32'hFFFF_FFFF);
        send_item(rbs_pkg::CMD_LOAD, 3, 2, 32'h0000_0000);
        send_item(rbs_pkg::CMD_LOAD, 1, 1, 32'hFF00_FF00);
        send_item(rbs_pkg::CMD_COMPUTE, 0, 0, 0);
        send_item(rbs_pkg::CMD_COMPUTE, 6, 4, 0);
        send_item(rbs_pkg::CMD_COMPUTE, 3, 2, 32'hFFFF_FFFF);
        send_item(rbs_pkg::CMD_COMPUTE, 1, 1, 0);
        send_item(rbs_pkg::CMD_COMPUTE, 4095, 4095, 0);
        send_item(rbs_pkg::CMD_LOAD, 4095, 4095, 32'hFFFF_FFFF);
        send_item(rbs_pkg::CMD_LOAD, 4, 0, 32'h1234_5678);
        send_item(rbs_pkg::CMD_LOAD, 0, 3, 32'h1234_5678);
        send_item(rbs_pkg::CMD_COMPUTE, 5, 3, 0);
        send_item(rbs_pkg::CMD_COMPUTE, 6, 0, 0);

        // Zero size registers act as one: single pixel source and target
        start_phase(0, 0, 0, 0);
        send_item(rbs_pkg::CMD_COMPUTE, 0, 0, 0);
        send_item(rbs_pkg::CMD_COMPUTE, 4095, 4095, 0);
        random_items(10, 0);

        // Oversize saturation and widest row
        start_phase(255, 1, 5000, 1);
        random_items(60, 0);

        // Tallest column, oversized target register with all bits set
        start_phase(1, 200, 1, 8191);
        random_items(60, 1);

        // Largest upscale along x with two rows, at full rate
        no_idle = 1;
        start_phase(128, 2, 4096, 4096);
        random_items(50, 0);
        no_idle = 0;

        // Random small source sizes with small or large targets
        for (int p = 0; p < 4; p++)
        begin
            start_phase($urandom_range(1, 8), $urandom_range(1, 8),
                        $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 4096),
                        $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 4096));
            random_items(40, 0);
        end

        drain();
        if (sb.errors == 0)
            $display("[rgba_bilinear_scaler] OK");
        else
            $display("[rgba_bilinear_scaler] ERROR");
        $finish;
    end
endmodule
